// File: rtl/lomec_pkg.sv
// ============================================================================
// Matching engine package
// Shared widths, codes, book entry types and instrument token tables.
// ============================================================================
package lomec_pkg;

    localparam int TRADERS_DEF    = 16;
    localparam int TOKENS_DEF     = 4;
    localparam int SYMBOLS_DEF    = 6;
    localparam int BOOK_DEPTH_DEF = 16;

    localparam int KNOWN_SYMBOLS = 6;
    localparam int ID_W          = 24;
    localparam int PX_W          = 16;
    localparam int QTY_W         = 16;
    localparam int TR_W          = 4;
    localparam int TK_W          = 2;
    localparam int BAL_W         = 48;
    localparam int KIND_W        = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACK     = 3'd0,
        KIND_EXEC    = 3'd1,
        KIND_REJECT  = 3'd2,
        KIND_DROP    = 3'd3,
        KIND_BALANCE = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        OP_ORDER    = 2'd0,
        OP_DEPOSIT  = 2'd1,
        OP_WITHDRAW = 2'd2,
        OP_QUERY    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_POP,
        CELL_SETQ,
        CELL_INSERT
    } t_cell_cmd;

    typedef struct packed {
        logic             valid;
        logic [ID_W-1:0]  id;
        logic [TR_W-1:0]  trader;
        logic [PX_W-1:0]  price;
        logic [QTY_W-1:0] qty;
    } t_entry;

    typedef struct packed {
        t_cell_cmd        cmd;
        logic             side;
        t_entry           ins;
        logic [QTY_W-1:0] qty;
    } t_cell_ctl;

    function automatic logic [TK_W-1:0] sym_base(input logic [2:0] sym);
        logic [TK_W-1:0] tk;
        unique case (sym)
            3'd0:    tk = 2'd1;
            3'd1:    tk = 2'd3;
            3'd2:    tk = 2'd0;
            3'd3:    tk = 2'd2;
            3'd4:    tk = 2'd1;
            3'd5:    tk = 2'd0;
            default: tk = 2'd0;
        endcase
        return tk;
    endfunction

    function automatic logic [TK_W-1:0] sym_quote(input logic [2:0] sym);
        logic [TK_W-1:0] tk;
        unique case (sym)
            3'd0:    tk = 2'd3;
            3'd1:    tk = 2'd1;
            3'd2:    tk = 2'd2;
            3'd3:    tk = 2'd0;
            3'd4:    tk = 2'd0;
            3'd5:    tk = 2'd1;
            default: tk = 2'd0;
        endcase
        return tk;
    endfunction

endpackage

// File: rtl/lomec_cell.sv
// ============================================================================
// Book cell
// Holds one resting order and shifts it to or from its neighbours on a pop
// or a sorted insertion.
// ============================================================================
module lomec_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_sel,
    input  logic                i_head,
    input  lomec_pkg::t_cell_ctl i_ctl,
    input  lomec_pkg::t_entry   i_prev,
    input  logic                i_prev_move,
    input  lomec_pkg::t_entry   i_next,
    output lomec_pkg::t_entry   o_ent,
    output logic                o_move
);

    lomec_pkg::t_entry r_ent;
    logic              w_worse;

    // A bid book is best-highest, an ask book best-lowest.
    assign w_worse = i_ctl.side ? (r_ent.price > i_ctl.ins.price)
                                : (r_ent.price < i_ctl.ins.price);
    assign o_move  = !r_ent.valid || w_worse;
    assign o_ent   = r_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.valid <= 1'b0;
        end else if (i_sel) begin
            unique case (i_ctl.cmd)
                lomec_pkg::CELL_POP: begin
                    r_ent <= i_next;
                end
                lomec_pkg::CELL_SETQ: begin
                    if (i_head) begin
                        r_ent.qty <= i_ctl.qty;
                    end
                end
                lomec_pkg::CELL_INSERT: begin
                    if (i_prev_move) begin
                        r_ent <= i_prev;
                    end else if (o_move) begin
                        r_ent <= i_ctl.ins;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// File: rtl/lomec_book.sv
// ============================================================================
// Book side
// A chain of cells kept packed at the front, best price first.
// ============================================================================
module lomec_book #(
    parameter int DEPTH = lomec_pkg::BOOK_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_sel,
    input  lomec_pkg::t_cell_ctl i_ctl,
    output lomec_pkg::t_entry    o_head,
    output logic                 o_full
);

    lomec_pkg::t_entry w_ent  [DEPTH];
    logic              w_move [DEPTH];

    for (genvar j = 0; j < DEPTH; j++) begin : g_cell
        lomec_pkg::t_entry w_prev;
        lomec_pkg::t_entry w_next;
        logic              w_prev_move;

        if (j == 0) begin : g_first
            assign w_prev      = '0;
            assign w_prev_move = 1'b0;
        end else begin : g_mid
            assign w_prev      = w_ent[j-1];
            assign w_prev_move = w_move[j-1];
        end

        if (j == DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_inner
            assign w_next = w_ent[j+1];
        end

        lomec_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_sel       (i_sel),
            .i_head      (j == 0),
            .i_ctl       (i_ctl),
            .i_prev      (w_prev),
            .i_prev_move (w_prev_move),
            .i_next      (w_next),
            .o_ent       (w_ent[j]),
            .o_move      (w_move[j])
        );
    end

    assign o_head = w_ent[0];
    assign o_full = w_ent[DEPTH-1].valid;

endmodule

// File: rtl/limit_order_matching_engine_core.sv
// ============================================================================
// Limit order matching engine core
// Balances in a memory, books as chains of cells, one command at a time.
// ============================================================================
//  Channel   Handshake          Contents
//  command   start / busy       op, trader, symbol, side, price, qty, token,
//                               amount
//  report    o_valid strobe     kind, trader, id, side, qty, price, balance,
//                               last
//
//  A command is taken when start is high and busy is low. Busy then stays high
//  until the command is done: a deposit, withdrawal or query, an unknown
//  symbol, or an order with each of its fills and the drop of its residue;
//  every balance update is a read-modify-write of the balance memory.
//  The last report is given in the cycle in which busy falls.
//  After reset busy stays high while the balance memory is cleared.
//  Reports cannot be stalled.
// ============================================================================
module limit_order_matching_engine_core #(
    parameter int TRADERS    = lomec_pkg::TRADERS_DEF,
    parameter int TOKENS     = lomec_pkg::TOKENS_DEF,
    parameter int SYMBOLS    = lomec_pkg::SYMBOLS_DEF,
    parameter int BOOK_DEPTH = lomec_pkg::BOOK_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [3:0]  i_trader,
    input  logic [2:0]  i_symbol,
    input  logic        i_order_side,
    input  logic [15:0] i_price,
    input  logic [15:0] i_qty,
    input  logic [1:0]  i_token,
    input  logic [31:0] i_amount,
    output logic        o_valid,
    output logic [2:0]  o_kind,
    output logic [3:0]  o_report_trader,
    output logic [23:0] o_order_id,
    output logic        o_report_side,
    output logic [15:0] o_exec_qty,
    output logic [15:0] o_exec_price,
    output logic [47:0] o_balance,
    output logic        o_last
);

    localparam int BAL_DEPTH = TRADERS * TOKENS;
    localparam int AW        = $clog2(BAL_DEPTH);
    localparam int NSYM      = (SYMBOLS < lomec_pkg::KNOWN_SYMBOLS) ? SYMBOLS
                                                                   : lomec_pkg::KNOWN_SYMBOLS;
    localparam int NB        = NSYM * 2;
    localparam int BW        = $clog2(NB);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_LOCK_RD, ST_LOCK_CHK, ST_MATCH, ST_FILL_B, ST_FILL_S,
        ST_FILL_Q, ST_REST, ST_RMW_WAIT, ST_RMW_WR, ST_REJECT, ST_QRD, ST_QUERY,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  trader;
        logic [23:0] id;
        logic        side;
        logic [15:0] qty;
        logic [15:0] price;
        logic [47:0] balance;
    } t_result;

    function automatic logic [AW-1:0] f_addr(input logic [3:0] tr, input logic [1:0] tk);
        return AW'(int'(tr) * TOKENS + int'(tk));
    endfunction

    t_state       r_state;
    t_state       r_ret;
    logic [AW-1:0] r_clr;
    logic [AW-1:0] r_addr;
    logic [47:0]  r_mem [BAL_DEPTH];
    logic [47:0]  r_rdata;
    logic [47:0]  r_delta;
    logic [31:0]  r_lock;

    logic [3:0]   r_tr;
    logic [2:0]   r_sym;
    logic         r_sd;
    logic [15:0]  r_px;
    logic [15:0]  r_q;
    logic         r_qzero;
    logic [BW-1:0] r_own_book;
    logic [BW-1:0] r_opp_book;

    logic [23:0]  r_next_id;
    logic [23:0]  r_id;
    logic [15:0]  r_rem;
    logic [15:0]  r_eq;
    logic [15:0]  r_xp;
    logic [15:0]  r_blim;
    logic [3:0]   r_btr;
    logic [23:0]  r_bid;
    logic [3:0]   r_str;
    logic [23:0]  r_sid;

    t_result      r_pend;
    logic         r_pend_v;
    t_result      r_out;
    logic         r_out_v;
    logic         r_out_last;

    lomec_pkg::t_entry    w_head [NB];
    logic                 w_full [NB];
    lomec_pkg::t_entry    w_opp;
    lomec_pkg::t_cell_ctl w_ctl;
    logic [BW-1:0]        w_book;
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [47:0]          w_wdata;
    logic                 w_short;
    logic                 w_cross;
    logic [15:0]          w_eq;
    logic [1:0]           w_base;
    logic [1:0]           w_quote;
    logic [23:0]          w_new_id;
    logic                 w_prod;
    t_result              w_res;

    assign w_opp    = w_head[r_opp_book];
    assign w_base   = lomec_pkg::sym_base(r_sym);
    assign w_quote  = lomec_pkg::sym_quote(r_sym);
    assign w_new_id = r_next_id + 24'd1;
    assign w_short  = $signed({r_rdata[47], r_rdata}) < $signed({17'd0, r_lock});
    assign w_cross  = r_sd ? !(r_px > w_opp.price) : !(r_px < w_opp.price);
    assign w_eq     = (r_rem < w_opp.qty) ? r_rem : w_opp.qty;

    // Book commands.
    always_comb begin
        w_ctl            = '0;
        w_ctl.cmd        = lomec_pkg::CELL_HOLD;
        w_ctl.side       = r_sd;
        w_ctl.ins.valid  = 1'b1;
        w_ctl.ins.id     = r_id;
        w_ctl.ins.trader = r_tr;
        w_ctl.ins.price  = r_px;
        w_ctl.ins.qty    = r_rem;
        w_ctl.qty        = w_opp.qty - w_eq;
        w_book           = r_opp_book;
        if (r_state == ST_MATCH && w_opp.valid && r_rem != 16'd0 && w_cross) begin
            w_ctl.cmd = (w_eq == w_opp.qty) ? lomec_pkg::CELL_POP : lomec_pkg::CELL_SETQ;
        end else if (r_state == ST_REST && r_rem != 16'd0 && !w_full[r_own_book]) begin
            w_ctl.cmd = lomec_pkg::CELL_INSERT;
            w_book    = r_own_book;
        end
    end

    for (genvar b = 0; b < NB; b++) begin : g_book
        lomec_book #(
            .DEPTH (BOOK_DEPTH)
        ) u_book (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_sel   ((w_book == BW'(b)) && (w_ctl.cmd != lomec_pkg::CELL_HOLD)),
            .i_ctl   (w_ctl),
            .o_head  (w_head[b]),
            .o_full  (w_full[b])
        );
    end

    // Balance memory.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_addr;
        w_wdata = r_rdata + r_delta;
        priority case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
            end
            ST_RMW_WR: begin
                w_we = 1'b1;
            end
            ST_LOCK_CHK: begin
                w_we    = !w_short;
                w_wdata = r_rdata - {16'd0, r_lock};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[r_addr];
    end

    // Report produced in this cycle.
    always_comb begin
        w_prod = 1'b0;
        w_res  = '0;
        priority case (r_state)
            ST_REJECT: begin
                w_prod = 1'b1;
                w_res  = '{lomec_pkg::KIND_REJECT, r_tr, 24'd0, r_sd, r_q, r_px, 48'd0};
            end
            ST_QUERY: begin
                w_prod = 1'b1;
                w_res  = '{lomec_pkg::KIND_BALANCE, r_tr, 24'd0, 1'b0, 16'd0, 16'd0,
                           r_qzero ? 48'd0 : r_rdata};
            end
            ST_LOCK_CHK: begin
                w_prod = 1'b1;
                w_res  = w_short
                    ? '{lomec_pkg::KIND_REJECT, r_tr, 24'd0, r_sd, r_q, r_px, 48'd0}
                    : '{lomec_pkg::KIND_ACK, r_tr, w_new_id, r_sd, r_q, r_px, 48'd0};
            end
            ST_FILL_B: begin
                w_prod = 1'b1;
                w_res  = '{lomec_pkg::KIND_EXEC, r_btr, r_bid, 1'b0, r_eq, r_xp, 48'd0};
            end
            ST_FILL_S: begin
                w_prod = 1'b1;
                w_res  = '{lomec_pkg::KIND_EXEC, r_str, r_sid, 1'b1, r_eq, r_xp, 48'd0};
            end
            ST_REST: begin
                w_prod = (r_rem != 16'd0) && w_full[r_own_book];
                w_res  = '{lomec_pkg::KIND_DROP, r_tr, r_id, r_sd, r_rem, r_px, 48'd0};
            end
            default: begin
            end
        endcase
    end

    // Control sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_next_id <= '0;
            r_pend_v  <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_out_v <= r_pend_v && (w_prod || (r_state == ST_FINISH));
            if (w_prod) begin
                r_pend   <= w_res;
                r_pend_v <= 1'b1;
                if (r_pend_v) begin
                    r_out      <= r_pend;
                    r_out_last <= 1'b0;
                end
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(BAL_DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (start) begin
                        r_tr       <= i_trader;
                        r_sym      <= i_symbol;
                        r_sd       <= i_order_side;
                        r_px       <= i_price;
                        r_q        <= i_qty;
                        r_own_book <= BW'({i_symbol, i_order_side});
                        r_opp_book <= BW'({i_symbol, !i_order_side});
                        r_qzero    <= !(int'(i_trader) < TRADERS && int'(i_token) < TOKENS);
                        r_ret      <= ST_FINISH;
                        unique case (i_op)
                            lomec_pkg::OP_ORDER: begin
                                r_addr <= f_addr(i_trader, i_order_side
                                                 ? lomec_pkg::sym_base(i_symbol)
                                                 : lomec_pkg::sym_quote(i_symbol));
                                if (int'(i_symbol) >= NSYM || int'(i_trader) >= TRADERS) begin
                                    r_state <= ST_REJECT;
                                end else begin
                                    r_state <= ST_LOCK_RD;
                                end
                            end
                            lomec_pkg::OP_DEPOSIT, lomec_pkg::OP_WITHDRAW: begin
                                r_addr  <= f_addr(i_trader, i_token);
                                r_delta <= (i_op == lomec_pkg::OP_DEPOSIT)
                                           ? {16'd0, i_amount} : 48'd0 - {16'd0, i_amount};
                                if (int'(i_trader) < TRADERS && int'(i_token) < TOKENS) begin
                                    r_state <= ST_RMW_WAIT;
                                end else begin
                                    r_state <= ST_FINISH;
                                end
                            end
                            default: begin
                                r_addr  <= f_addr(i_trader, i_token);
                                r_state <= ST_QRD;
                            end
                        endcase
                    end
                end
                ST_LOCK_RD: begin
                    r_lock  <= r_sd ? {16'd0, r_q} : r_q * r_px;
                    r_state <= ST_LOCK_CHK;
                end
                ST_LOCK_CHK: begin
                    if (w_short) begin
                        r_state <= ST_FINISH;
                    end else begin
                        r_next_id <= w_new_id;
                        r_id      <= w_new_id;
                        r_rem     <= r_q;
                        r_state   <= ST_MATCH;
                    end
                end
                ST_MATCH: begin
                    if (w_opp.valid && r_rem != 16'd0 && w_cross) begin
                        r_eq  <= w_eq;
                        r_rem <= r_rem - w_eq;
                        r_xp  <= 16'(({1'b0, r_px} + {1'b0, w_opp.price}) >> 1);
                        if (!r_sd) begin
                            r_btr  <= r_tr;
                            r_bid  <= r_id;
                            r_blim <= r_px;
                            r_str  <= w_opp.trader;
                            r_sid  <= w_opp.id;
                        end else begin
                            r_btr  <= w_opp.trader;
                            r_bid  <= w_opp.id;
                            r_blim <= w_opp.price;
                            r_str  <= r_tr;
                            r_sid  <= r_id;
                        end
                        r_state <= ST_FILL_B;
                    end else begin
                        r_state <= ST_REST;
                    end
                end
                ST_FILL_B: begin
                    r_delta <= {16'd0, 32'(r_eq) * 32'(r_blim - r_xp)};
                    r_addr  <= f_addr(r_btr, w_quote);
                    r_ret   <= ST_FILL_S;
                    r_state <= ST_RMW_WAIT;
                end
                ST_FILL_S: begin
                    r_delta <= {32'd0, r_eq};
                    r_addr  <= f_addr(r_btr, w_base);
                    r_ret   <= ST_FILL_Q;
                    r_state <= ST_RMW_WAIT;
                end
                ST_FILL_Q: begin
                    r_delta <= {16'd0, 32'(r_eq) * 32'(r_xp)};
                    r_addr  <= f_addr(r_str, w_quote);
                    r_ret   <= ST_MATCH;
                    r_state <= ST_RMW_WAIT;
                end
                ST_REST: begin
                    if (r_rem != 16'd0 && w_full[r_own_book]) begin
                        r_delta <= r_sd ? {32'd0, r_rem} : {16'd0, 32'(r_rem) * 32'(r_px)};
                        r_addr  <= f_addr(r_tr, r_sd ? w_base : w_quote);
                        r_ret   <= ST_FINISH;
                        r_state <= ST_RMW_WAIT;
                    end else begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_RMW_WAIT: begin
                    r_state <= ST_RMW_WR;
                end
                ST_RMW_WR: begin
                    r_state <= r_ret;
                end
                ST_REJECT: begin
                    r_state <= ST_FINISH;
                end
                ST_QRD: begin
                    r_state <= ST_QUERY;
                end
                ST_QUERY: begin
                    r_state <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (r_pend_v) begin
                        r_out      <= r_pend;
                        r_out_last <= 1'b1;
                        r_pend_v   <= 1'b0;
                    end
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy            = (r_state != ST_IDLE);
    assign o_valid         = r_out_v;
    assign o_kind          = r_out.kind;
    assign o_report_trader = r_out.trader;
    assign o_order_id      = r_out.id;
    assign o_report_side   = r_out.side;
    assign o_exec_qty      = r_out.qty;
    assign o_exec_price    = r_out.price;
    assign o_balance       = r_out.balance;
    assign o_last          = r_out_last;

endmodule
